[rtl/sfcr_pkg.sv]
// shared types and constants for the serial frame checksum receiver
// no dependencies; imported by sfcr_decode and serial_frame_checksum_receiver
package sfcr_pkg;

    localparam int FRAME_DEPTH_DEF = 16;

    localparam logic [7:0] MARK_START     = 8'hA0;
    localparam logic [7:0] MARK_END       = 8'hA1;
    localparam logic [7:0] CMD_SET_COUNT  = 8'hF2;
    localparam logic [7:0] CMD_FORWARD    = 8'hF1;
    localparam logic [7:0] TEXT_LOW       = 8'h20;
    localparam logic [7:0] TEXT_HIGH      = 8'h7E;
    localparam logic [7:0] CHAR_CR        = 8'h0D;
    localparam logic [7:0] CHAR_LF        = 8'h0A;
    localparam logic [7:0] COUNT_AT_RESET = 8'd30;

    // bytes that must already be held before an end marker can close a frame
    localparam int MIN_HELD = 5;

    typedef enum logic [2:0] {
        EV_TAKEN   = 3'd0,
        EV_COUNT   = 3'd1,
        EV_FWD     = 3'd2,
        EV_UNKNOWN = 3'd3,
        EV_BADSUM  = 3'd4,
        EV_TEXT    = 3'd5
    } ev_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FWD_RD,
        ST_FWD_OUT
    } state_t;

    // outcome of one received byte
    typedef struct packed {
        logic is_text;
        ev_t  ev;
        logic ok;
        logic fwd;
        logic set_cnt;
        logic clear;
    } dec_t;

endpackage

[rtl/serial_frame_checksum_receiver.sv]
// top level of the serial frame checksum receiver: control, frame ram, result register
// depends on sfcr_pkg, sfcr_ram and sfcr_decode
//
// usage
//   s_ channel: one received serial byte per transfer, s_tdata[7:0] = rx_byte
//   m_ channel: result transfers; s_tdata of one byte gives one or more results,
//     m_tlast marks the final result of that byte
//   text bytes (printable, cr, lf) give one text result and leave the frame alone
//   other bytes are written into the frame ram; an end marker after at least
//     five held bytes closes the frame and tests its checksum
//   a non-forward result enters the output register in the cycle after its byte
//   throughput: one byte per cycle while no forward command runs and the
//     result register is free; a good forward frame is read out byte by
//     byte via a read state, then an output state for the registered ram data
//   s_tready is low while a forward readout runs or the result register is full
//     and not being taken
//   reset: synchronous active-low aresetn empties the frame, sets the poll count
//     to 30 and drops m_tvalid; ram contents need no clearing since only bytes
//     of the current frame are ever read
//   stall: a held result keeps m_tdata and m_tlast stable until transfer;
//     input is held off meanwhile
module serial_frame_checksum_receiver #(
    parameter int FRAME_DEPTH = sfcr_pkg::FRAME_DEPTH_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] rx_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [2:0] event_res, [10:3] fwd_byte,
                                   // [18:11] poll_count, [19] frame_ok, rest zero
    output logic        m_tlast
);
    import sfcr_pkg::*;

    localparam int AW = $clog2(FRAME_DEPTH);
    localparam int CW = $clog2(FRAME_DEPTH + 1);

    // control state
    state_t        state_reg, state_next;
    logic [CW-1:0] fill_reg, fill_next;
    logic [7:0]    count_reg, count_next;
    logic          m_valid_reg, m_valid_next;
    logic [AW-1:0] rd_idx_reg, rd_idx_next;
    logic [AW-1:0] fwd_end_reg, fwd_end_next;

    // running frame facts
    logic [7:0]    sum_reg, sum_next;
    logic [7:0]    prev_reg, prev_next;
    logic [7:0]    cmd_reg, cmd_next;
    logic [7:0]    arg_reg, arg_next;

    // result register payload
    ev_t           ev_reg, ev_next;
    logic [7:0]    byte_reg, byte_next;
    logic [7:0]    poll_reg, poll_next;
    logic          ok_reg, ok_next;
    logic          last_reg, last_next;

    logic          out_free;
    logic          s_accept;
    logic          wr_en;
    logic          rd_en;
    logic [7:0]    rd_data;
    dec_t          dec;

    sfcr_decode #(
        .FRAME_DEPTH(FRAME_DEPTH)
    ) u_decode (
        .rx_byte (s_tdata),
        .fill    (fill_reg),
        .sum     (sum_reg),
        .prev    (prev_reg),
        .cmd     (cmd_reg),
        .dec     (dec)
    );

    // frame store: written at the fill position, read during forward readout
    sfcr_ram #(
        .WIDTH(8),
        .DEPTH(FRAME_DEPTH)
    ) u_frame_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (fill_reg[AW-1:0]),
        .wr_data (s_tdata),
        .rd_en   (rd_en),
        .rd_addr (rd_idx_reg),
        .rd_data (rd_data)
    );

    assign out_free = !m_valid_reg || m_tready;
    assign s_tready = (state_reg == ST_IDLE) && out_free;
    assign s_accept = s_tvalid && s_tready;

    always_comb begin
        state_next   = state_reg;
        fill_next    = fill_reg;
        count_next   = count_reg;
        rd_idx_next  = rd_idx_reg;
        fwd_end_next = fwd_end_reg;
        sum_next     = sum_reg;
        prev_next    = prev_reg;
        cmd_next     = cmd_reg;
        arg_next     = arg_reg;
        ev_next      = ev_reg;
        byte_next    = byte_reg;
        poll_next    = poll_reg;
        ok_next      = ok_reg;
        last_next    = last_reg;
        wr_en        = 1'b0;
        rd_en        = 1'b0;
        m_valid_next = m_valid_reg && !m_tready;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    if (dec.is_text) begin
                        m_valid_next = 1'b1;
                        ev_next      = EV_TEXT;
                        byte_next    = '0;
                        poll_next    = count_reg;
                        ok_next      = 1'b0;
                        last_next    = 1'b1;
                    end else begin
                        wr_en     = 1'b1;
                        // first byte of a frame restarts the running sum
                        sum_next  = (fill_reg == '0) ? s_tdata : sum_reg + s_tdata;
                        prev_next = s_tdata;
                        if (fill_reg == CW'(1)) begin
                            cmd_next = s_tdata;
                        end
                        if (fill_reg == CW'(2)) begin
                            arg_next = s_tdata;
                        end
                        fill_next = dec.clear ? '0 : fill_reg + CW'(1);
                        if (dec.set_cnt) begin
                            count_next = arg_reg;
                        end
                        if (dec.fwd) begin
                            // frame runs from entry 0 to the byte just written
                            state_next   = ST_FWD_RD;
                            rd_idx_next  = '0;
                            fwd_end_next = fill_reg[AW-1:0];
                        end else begin
                            m_valid_next = 1'b1;
                            ev_next      = dec.ev;
                            byte_next    = '0;
                            poll_next    = dec.set_cnt ? arg_reg : count_reg;
                            ok_next      = dec.ok;
                            last_next    = 1'b1;
                        end
                    end
                end
            end
            ST_FWD_RD: begin
                rd_en      = 1'b1;
                state_next = ST_FWD_OUT;
            end
            ST_FWD_OUT: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    ev_next      = EV_FWD;
                    byte_next    = rd_data;
                    poll_next    = count_reg;
                    ok_next      = 1'b1;
                    last_next    = (rd_idx_reg == fwd_end_reg);
                    if (rd_idx_reg == fwd_end_reg) begin
                        state_next = ST_IDLE;
                    end else begin
                        rd_idx_next = rd_idx_reg + AW'(1);
                        state_next  = ST_FWD_RD;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            fill_reg    <= '0;
            count_reg   <= COUNT_AT_RESET;
            m_valid_reg <= 1'b0;
            rd_idx_reg  <= '0;
            fwd_end_reg <= '0;
        end else begin
            state_reg   <= state_next;
            fill_reg    <= fill_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
            rd_idx_reg  <= rd_idx_next;
            fwd_end_reg <= fwd_end_next;
        end
    end

    // payload, no reset needed
    always_ff @(posedge aclk) begin
        sum_reg  <= sum_next;
        prev_reg <= prev_next;
        cmd_reg  <= cmd_next;
        arg_reg  <= arg_next;
        ev_reg   <= ev_next;
        byte_reg <= byte_next;
        poll_reg <= poll_next;
        ok_reg   <= ok_next;
        last_reg <= last_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tlast  = last_reg;
    assign m_tdata  = {4'b0000, ok_reg, poll_reg, byte_reg, ev_reg};

    // the frame never holds a full store between bytes
    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg < CW'(FRAME_DEPTH))
        else $error("frame fill reached store depth");

    // text bytes never touch the frame
    a_text_keeps_fill: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && dec.is_text) |=> $stable(fill_reg))
        else $error("text byte changed frame fill");

    // no input is taken during a forward readout
    a_no_accept_in_fwd: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_IDLE) |-> !s_tready)
        else $error("input ready during forward readout");

    // a forward readout only starts from a good forward frame
    a_fwd_start: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE && state_next == ST_FWD_RD) |-> (s_accept && dec.fwd))
        else $error("forward readout without good forward frame");

endmodule

[rtl/sfcr_ram.sv]
// generic single-port-write, single-port-read ram with registered read data
// no dependencies
module sfcr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[rtl/sfcr_decode.sv]
// classifies one received byte against the running frame state
// depends on sfcr_pkg
module sfcr_decode #(
    parameter int FRAME_DEPTH = sfcr_pkg::FRAME_DEPTH_DEF
) (
    input  logic [7:0]                       rx_byte,
    input  logic [$clog2(FRAME_DEPTH+1)-1:0] fill,
    input  logic [7:0]                       sum,
    input  logic [7:0]                       prev,
    input  logic [7:0]                       cmd,
    output sfcr_pkg::dec_t                   dec
);
    import sfcr_pkg::*;

    localparam int CW = $clog2(FRAME_DEPTH + 1);

    logic [CW-1:0] fill_new;
    logic [7:0]    total;
    logic [7:0]    rest;
    logic          complete;
    logic          first_bad;
    logic          overlong;

    always_comb begin
        fill_new  = fill + CW'(1);
        total     = sum + rx_byte;
        rest      = total - prev;     // every byte but the checksum byte
        // a held frame always starts with the start marker
        complete  = (fill >= CW'(MIN_HELD)) && (rx_byte == MARK_END);
        first_bad = (fill == '0) && (rx_byte != MARK_START);
        overlong  = (fill_new == CW'(FRAME_DEPTH));

        dec.is_text = ((rx_byte >= TEXT_LOW) && (rx_byte <= TEXT_HIGH))
                      || (rx_byte == CHAR_CR) || (rx_byte == CHAR_LF);
        dec.clear   = complete || first_bad || overlong;
        dec.ok      = 1'b0;
        dec.fwd     = 1'b0;
        dec.set_cnt = 1'b0;
        dec.ev      = EV_TAKEN;
        if (complete) begin
            if (rest == prev) begin
                dec.ok = 1'b1;
                unique case (cmd)
                    CMD_SET_COUNT: begin
                        dec.ev      = EV_COUNT;
                        dec.set_cnt = 1'b1;
                    end
                    CMD_FORWARD: begin
                        dec.ev  = EV_FWD;
                        dec.fwd = 1'b1;
                    end
                    default: begin
                        dec.ev = EV_UNKNOWN;
                    end
                endcase
            end else begin
                dec.ev = EV_BADSUM;
            end
        end
    end

endmodule

[bench/serial_frame_checksum_receiver_tb.sv]
// self-checking bench for serial_frame_checksum_receiver: byte stream in, event stream out
// depends on sfcr_pkg and the receiver rtl; keeps its own frame tracker to predict results
module serial_frame_checksum_receiver_tb;
    import sfcr_pkg::*;

    localparam int STORE_DEPTH   = FRAME_DEPTH_DEF;
    localparam int HOLD_CYCLES   = 80;     // long receiver hold-off to back up the block
    localparam int QUIET_LIMIT   = 4000;   // cycles with no transfer before giving up
    localparam int TAIL_CYCLES   = 40;     // covers a full 16-byte readout after the drain
    localparam int PHASE_ITEMS   = 48;     // least number of bytes sent per handshake phase
    localparam int REPORT_MAX    = 10;

    // one expected result transfer
    typedef struct {
        ev_t        ev;
        logic [7:0] fwd;
        logic [7:0] cnt;
        logic       ok;
        logic       last;
    } event_rec_t;

    // one directed byte; lit marks rows whose result is written out by hand
    typedef struct {
        logic [7:0] rx;
        bit         lit;
        ev_t        ev;
        logic [7:0] cnt;
        logic       ok;
    } stim_row_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = 8'h00;   // [7:0] rx_byte
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;            // [2:0] event_res, [10:3] fwd_byte,
                                     // [18:11] poll_count, [19] frame_ok, rest zero
    logic        m_tlast;

    // frame tracker state, mirrors what the block should hold
    logic [7:0]  held_bytes [STORE_DEPTH];
    int          held_count = 0;
    logic [7:0]  poll_now   = COUNT_AT_RESET;

    event_rec_t  due_events [$];

    int src_idle_pct = 0;
    int snk_idle_pct = 0;
    int stall_ticket = 0;
    int stall_served = 0;
    int hold_left    = 0;
    int quiet_run    = 0;
    int bytes_sent   = 0;
    int results_seen = 0;
    int mismatches   = 0;
    int ev_hits [6]  = '{default: 0};

    // directed bytes: text class edges, a wrong start, then one frame per command
    // outcome and a frame with a broken checksum
    stim_row_t dir_rows [29] = '{
        '{8'h20, 1'b1, EV_TEXT,    8'd30, 1'b0},   // lowest printable
        '{8'h7E, 1'b1, EV_TEXT,    8'd30, 1'b0},   // highest printable
        '{8'h0D, 1'b1, EV_TEXT,    8'd30, 1'b0},   // cr
        '{8'h0A, 1'b1, EV_TEXT,    8'd30, 1'b0},   // lf
        '{8'h00, 1'b1, EV_TAKEN,   8'd30, 1'b0},   // wrong start byte empties the store
        // set poll count to 0xff
        '{8'hA0, 1'b0, EV_TAKEN,   8'd0,  1'b0},
        '{8'hF2, 1'b0, EV_TAKEN,   8'd0,  1'b0},
        '{8'hFF, 1'b0, EV_TAKEN,   8'd0,  1'b0},
        '{8'h80, 1'b0, EV_TAKEN,   8'd0,  1'b0},
        '{8'hB2, 1'b0, EV_TAKEN,   8'd0,  1'b0},
        '{8'hA1, 1'b1, EV_COUNT,   8'hFF, 1'b1},
        // forward the frame back out
        '{8'hA0, 1'b0, EV_TAKEN,   8'd0,  1'b0},
        '{8'hF1, 1'b0, EV_TAKEN,   8'd0,  1'b0},
        '{8'h90, 1'b0, EV_TAKEN,   8'd0,  1'b0},
        '{8'h00, 1'b0, EV_TAKEN,   8'd0,  1'b0},
        '{8'hC2, 1'b0, EV_TAKEN,   8'd0,  1'b0},
        '{8'hA1, 1'b0, EV_TAKEN,   8'd0,  1'b0},
        // good checksum, command nobody knows
        '{8'hA0, 1'b0, EV_TAKEN,   8'd0,  1'b0},
        '{8'hC0, 1'b0, EV_TAKEN,   8'd0,  1'b0},
        '{8'h00, 1'b0, EV_TAKEN,   8'd0,  1'b0},
        '{8'h00, 1'b0, EV_TAKEN,   8'd0,  1'b0},
        '{8'h01, 1'b0, EV_TAKEN,   8'd0,  1'b0},
        '{8'hA1, 1'b1, EV_UNKNOWN, 8'hFF, 1'b1},
        // checksum byte wrong, count must stay
        '{8'hA0, 1'b0, EV_TAKEN,   8'd0,  1'b0},
        '{8'hF2, 1'b0, EV_TAKEN,   8'd0,  1'b0},
        '{8'h10, 1'b0, EV_TAKEN,   8'd0,  1'b0},
        '{8'h00, 1'b0, EV_TAKEN,   8'd0,  1'b0},
        '{8'h00, 1'b0, EV_TAKEN,   8'd0,  1'b0},
        '{8'hA1, 1'b1, EV_BADSUM,  8'hFF, 1'b0}
    };

    serial_frame_checksum_receiver uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always #5 aclk = ~aclk;

    // printable ascii, cr and lf never reach the frame store
    function automatic bit is_text(input logic [7:0] b);
        return (b >= TEXT_LOW && b <= TEXT_HIGH) || b == CHAR_CR || b == CHAR_LF;
    endfunction

    // binary byte that can neither be diverted nor close a frame early
    function automatic logic [7:0] rand_bin();
        logic [7:0] v;
        do v = 8'($urandom_range(255)); while (is_text(v) || v == MARK_END);
        return v;
    endfunction

    function automatic logic [7:0] rand_text();
        int pick;
        pick = $urandom_range(9);
        if (pick == 0) return CHAR_CR;
        if (pick == 1) return CHAR_LF;
        return 8'($urandom_range(TEXT_HIGH, TEXT_LOW));
    endfunction

    function automatic void note_event(input ev_t ev, input logic [7:0] fwd, input logic ok);
        due_events.push_back('{ev, fwd, poll_now, ok, 1'b0});
    endfunction

    // frame tracker: works out every result one received byte causes
    task automatic digest_byte(input logic [7:0] b);
        logic [7:0] chk;
        logic [7:0] sum;
        int         i;
        if (is_text(b)) begin
            note_event(EV_TEXT, 8'h00, 1'b0);
        end else begin
            if (held_count < STORE_DEPTH) begin
                held_bytes[held_count] = b;
                held_count++;
            end else begin
                held_bytes[0] = b;
                held_count = 1;
            end
            if (held_count > MIN_HELD && held_bytes[0] == MARK_START &&
                held_bytes[held_count-1] == MARK_END) begin
                // checksum covers every held byte except the checksum itself
                chk = held_bytes[held_count-2];
                sum = 8'h00;
                for (i = 0; i < held_count; i++)
                    if (i != held_count - 2) sum += held_bytes[i];
                if (sum != chk) begin
                    note_event(EV_BADSUM, 8'h00, 1'b0);
                end else if (held_bytes[1] == CMD_SET_COUNT) begin
                    poll_now = held_bytes[2];
                    note_event(EV_COUNT, 8'h00, 1'b1);
                end else if (held_bytes[1] == CMD_FORWARD) begin
                    for (i = 0; i < held_count; i++)
                        note_event(EV_FWD, held_bytes[i], 1'b1);
                end else begin
                    note_event(EV_UNKNOWN, 8'h00, 1'b1);
                end
                held_count = 0;
            end else begin
                if (held_bytes[0] != MARK_START) held_count = 0;
                note_event(EV_TAKEN, 8'h00, 1'b0);
            end
            // a full store that did not close a frame starts over
            if (held_count > STORE_DEPTH - 1) held_count = 0;
        end
        due_events[due_events.size()-1].last = 1'b1;
    endtask

    // offer one byte, with random gaps ahead of it, and wait for the transfer
    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        do @(posedge aclk); while (!s_tready);
        digest_byte(b);
        bytes_sent++;
    endtask

    // stop offering until every predicted result has been taken
    task automatic drain_results();
        s_tvalid <= 1'b0;
        wait (due_events.size() == 0);
        @(posedge aclk);
    endtask

    // well-formed frame with random content; spoil swaps in a wrong checksum
    task automatic send_frame(input logic [7:0] cmd, input int npay, input bit spoil);
        logic [7:0] fb [$];
        logic [7:0] good;
        logic [7:0] chk;
        int         i;
        fb = {MARK_START, cmd};
        for (i = 0; i < npay; i++) fb.push_back(rand_bin());
        // reroll the last payload byte until the checksum is a binary byte
        do begin
            fb[npay+1] = rand_bin();
            good = MARK_END;
            foreach (fb[k]) good += fb[k];
        end while (is_text(good) || good == MARK_END);
        chk = good;
        if (spoil)
            do chk = rand_bin(); while (chk == good);
        fb.push_back(chk);
        fb.push_back(MARK_END);
        foreach (fb[k]) begin
            // stray text in mid-frame is diverted and leaves the frame intact
            if ($urandom_range(99) < 4) send_byte(rand_text());
            send_byte(fb[k]);
        end
    endtask

    task automatic random_phase(input int quota, input bit with_hold);
        int  start;
        int  kind;
        int  npay;
        logic [7:0] cmd;
        start = bytes_sent;
        if (with_hold) begin
            // receiver holds off while a full-size readout is queued behind it
            stall_ticket++;
            send_frame(CMD_FORWARD, STORE_DEPTH - 4, 1'b0);
        end
        while (bytes_sent - start < quota) begin
            kind = $urandom_range(99);
            if (kind < 70) begin
                case ($urandom_range(9))
                    0, 1, 2, 3: cmd = CMD_FORWARD;
                    4, 5, 6:    cmd = CMD_SET_COUNT;
                    default:    cmd = rand_bin();
                endcase
                npay = ($urandom_range(3) == 0) ? $urandom_range(STORE_DEPTH - 4, 6)
                                                : $urandom_range(5, 2);
                send_frame(cmd, npay, $urandom_range(99) < 12);
            end else if (kind < 80) begin
                // start marker and following bytes that together fill or overrun the store
                send_byte(MARK_START);
                repeat ($urandom_range(18, 15)) send_byte(rand_bin());
            end else begin
                repeat ($urandom_range(4, 1)) send_byte(8'($urandom_range(255)));
            end
        end
    endtask

    task automatic flag_fault(input string what);
        mismatches++;
        if (mismatches <= REPORT_MAX) $display("mismatch %0d: %s", mismatches, what);
    endtask

    // result side: check each transfer, then decide on m_tready for the next edge
    always @(posedge aclk) begin : result_side
        event_rec_t want;
        if (aresetn && m_tvalid && m_tready) begin
            results_seen++;
            if (m_tdata[2:0] < 6) ev_hits[m_tdata[2:0]]++;
            if (due_events.size() == 0) begin
                flag_fault($sformatf("unexpected result tdata=%h tlast=%b", m_tdata, m_tlast));
            end else begin
                want = due_events.pop_front();
                if (m_tdata[2:0] !== want.ev || m_tdata[10:3] !== want.fwd ||
                    m_tdata[18:11] !== want.cnt || m_tdata[19] !== want.ok ||
                    m_tdata[23:20] !== 4'h0 || m_tlast !== want.last)
                    flag_fault($sformatf(
                        "exp ev=%0d fwd=%h cnt=%h ok=%b last=%b, got ev=%0d fwd=%h cnt=%h ok=%b last=%b pad=%h",
                        want.ev, want.fwd, want.cnt, want.ok, want.last,
                        m_tdata[2:0], m_tdata[10:3], m_tdata[18:11], m_tdata[19], m_tlast,
                        m_tdata[23:20]));
            end
        end
        if (stall_served != stall_ticket) begin
            stall_served = stall_ticket;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= snk_idle_pct);
        end
    end

    // watchdog: too long without any transfer on either side
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_run <= 0;
        end else if (quiet_run >= QUIET_LIMIT) begin
            $display("no transfer for %0d cycles, %0d results still due",
                     QUIET_LIMIT, due_events.size());
            $display("RESULT: ERROR");
            $finish;
        end else begin
            quiet_run <= quiet_run + 1;
        end
    end

    initial begin
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // phase one: sender idles lightly, receiver heavily
        src_idle_pct = 21;
        snk_idle_pct = 57;
        foreach (dir_rows[r]) begin
            send_byte(dir_rows[r].rx);
            if (dir_rows[r].lit) begin
                void'(due_events.pop_back());
                due_events.push_back('{dir_rows[r].ev, 8'h00, dir_rows[r].cnt,
                                       dir_rows[r].ok, 1'b1});
            end
        end
        random_phase(PHASE_ITEMS, 1'b1);
        drain_results();

        // phase two: roles swapped
        src_idle_pct = 57;
        snk_idle_pct = 21;
        random_phase(PHASE_ITEMS, 1'b0);
        drain_results();

        // phase three: both sides at full rate, with one more long hold-off
        src_idle_pct = 0;
        snk_idle_pct = 0;
        random_phase(PHASE_ITEMS, 1'b1);
        drain_results();

        // give a late or extra result the chance to show up
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (due_events.size() != 0)
            flag_fault($sformatf("%0d results never arrived", due_events.size()));

        $display("sent %0d bytes over three idle patterns, %0d results checked, %0d mismatches",
                 bytes_sent, results_seen, mismatches);
        $display("events: taken %0d, count set %0d, forwarded %0d, unknown %0d, bad sum %0d, text %0d",
                 ev_hits[0], ev_hits[1], ev_hits[2], ev_hits[3], ev_hits[4], ev_hits[5]);
        if (mismatches == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

[files.f]
rtl/sfcr_pkg.sv
rtl/sfcr_ram.sv
rtl/sfcr_decode.sv
rtl/serial_frame_checksum_receiver.sv
bench/serial_frame_checksum_receiver_tb.sv
